/* rtl/assert_macros.svh */
// Assertion macros for the RTL files of the decimal string parser.
// No dependencies; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/sdsf_pkg.sv */
// Package for the decimal string parser: parser phases, parse state struct
// and character constants. No dependencies.
`default_nettype none
package sdsf_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_ERR
    } phase_t;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    typedef struct packed {
        phase_t       phase;
        logic [63:0]  int_acc;
        logic [59:0]  frac_acc;
        logic [4:0]   frac_cnt;
        logic         ovf;
        logic         trunc;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:    PH_START,
        int_acc:  64'd0,
        frac_acc: 60'd0,
        frac_cnt: 5'd0,
        ovf:      1'b0,
        trunc:    1'b0
    };

endpackage
`default_nettype wire

/* rtl/sdsf_step.sv */
// One character step of the decimal grammar: next parse state from the
// current state and one character. Depends on sdsf_pkg.
`default_nettype none
module sdsf_step #(
    parameter int MAX_FRAC_DIGITS = 18
) (
    input  sdsf_pkg::parse_state_t cur,
    input  logic [7:0]             character,
    input  logic                   has_char,
    output sdsf_pkg::parse_state_t nxt
);
    import sdsf_pkg::*;

    logic        is_digit;
    logic        is_dot;
    logic        is_zero;
    logic [3:0]  digit;
    logic [67:0] int_wide;
    logic [67:0] int_prod;
    logic [59:0] frac_prod;
    logic        int_wraps;
    logic        frac_room;
    logic [7:0]  char_off;
    parse_state_t st;

    assign char_off  = character - CH_ZERO;
    assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
    assign is_dot    = (character == CH_DOT);
    assign is_zero   = (character == CH_ZERO);
    assign digit     = is_digit ? char_off[3:0] : 4'd0;

    // Times ten plus the digit as two shifts and two adds; the top four bits of the integer product show overflow.
    assign int_wide  = {4'd0, cur.int_acc};
    assign int_prod  = (int_wide << 3) + (int_wide << 1) + {64'd0, digit};
    assign int_wraps = |int_prod[67:64];
    assign frac_prod = (cur.frac_acc << 3) + (cur.frac_acc << 1) + {56'd0, digit};
    assign frac_room = cur.frac_cnt < 5'(MAX_FRAC_DIGITS);

    always_comb
    begin
        st = cur;
        case (cur.phase)
            PH_START:
            begin
                if (is_dot)
                begin
                    st.phase = PH_DOT;
                end
                else if (is_zero)
                begin
                    st.phase = PH_ZERO;
                end
                else if (is_digit)
                begin
                    st.phase = PH_INT;
                    if (!cur.ovf)
                    begin
                        if (int_wraps)
                        begin
                            st.int_acc = '1;
                            st.ovf     = 1'b1;
                        end
                        else
                        begin
                            st.int_acc = int_prod[63:0];
                        end
                    end
                end
                else
                begin
                    st.phase = PH_ERR;
                end
            end
            PH_ZERO:
            begin
                st.phase = is_dot ? PH_DOT : PH_ERR;
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    if (!cur.ovf)
                    begin
                        if (int_wraps)
                        begin
                            st.int_acc = '1;
                            st.ovf     = 1'b1;
                        end
                        else
                        begin
                            st.int_acc = int_prod[63:0];
                        end
                    end
                end
                else if (is_dot)
                begin
                    st.phase = PH_DOT;
                end
                else
                begin
                    st.phase = PH_ERR;
                end
            end
            PH_DOT, PH_FRAC:
            begin
                if (is_digit)
                begin
                    st.phase = PH_FRAC;
                    if (frac_room)
                    begin
                        st.frac_acc = frac_prod;
                        st.frac_cnt = cur.frac_cnt + 5'd1;
                    end
                    else
                    begin
                        st.trunc = 1'b1;
                    end
                end
                else
                begin
                    st.phase = PH_ERR;
                end
            end
            default:
            begin
                st.phase = PH_ERR;
            end
        endcase
        nxt = has_char ? st : cur;
    end

endmodule
`default_nettype wire

/* rtl/strict_decimal_string_to_fixed_top.sv */
// A result appears on the outputs from the result register once the item carrying
// last has passed the input register and moved on (input reg, result reg).
// Throughput: one item per cycle; a held result stalls only items with last.
// The step logic is one times-ten shift-add per accumulator between registers.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to its start state with all accumulators and flags cleared.
`default_nettype none
module strict_decimal_string_to_fixed_top #(
    parameter int MAX_FRAC_DIGITS = 18
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    input  logic        has_char,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [63:0] int_part,
    output logic [59:0] frac_value,
    output logic [4:0]  frac_count,
    output logic        int_overflow,
    output logic        frac_truncated
);
    import sdsf_pkg::*;
    `include "assert_macros.svh"

    // Input register: one item waits here while the parse state catches up.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  char_reg;
    logic        has_char_reg;
    logic        last_reg;

    // Parse state carried from one character to the next.
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t stepped;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        valid_res_reg;
    logic [63:0] int_part_reg;
    logic [59:0] frac_value_reg;
    logic [4:0]  frac_count_reg;
    logic        int_overflow_reg;
    logic        frac_truncated_reg;

    logic        proceed;
    logic        finish;
    logic        ok;

    sdsf_step #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_step (
        .cur       (state_reg),
        .character (char_reg),
        .has_char  (has_char_reg),
        .nxt       (stepped)
    );

    // An item without last never needs the result register, so it moves on
    // at once. An item with last moves on when the result register is free
    // or is being emptied in this cycle.
    assign proceed  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign finish   = proceed && last_reg;
    assign in_ready = !in_valid_reg || proceed;

    // The string is good only if it ends after a complete integer or after
    // at least one fraction digit.
    assign ok = (stepped.phase == PH_ZERO) || (stepped.phase == PH_INT) ||
                (stepped.phase == PH_FRAC);

    always_comb
    begin
        in_valid_next  = in_ready ? in_valid : in_valid_reg;
        out_valid_next = finish ? 1'b1 : (out_valid_reg && !out_ready);
        if (finish)
        begin
            state_next = PARSE_RESET;
        end
        else if (proceed)
        begin
            state_next = stepped;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            char_reg     <= character;
            has_char_reg <= has_char;
            last_reg     <= last;
        end
        // A rejected string reports all fields as zero.
        if (finish)
        begin
            valid_res_reg      <= ok;
            int_part_reg       <= ok ? stepped.int_acc : 64'd0;
            frac_value_reg     <= ok ? stepped.frac_acc : 60'd0;
            frac_count_reg     <= ok ? stepped.frac_cnt : 5'd0;
            int_overflow_reg   <= ok && stepped.ovf;
            frac_truncated_reg <= ok && stepped.trunc;
        end
    end

    assign out_valid      = out_valid_reg;
    assign valid_res      = valid_res_reg;
    assign int_part       = int_part_reg;
    assign frac_value     = frac_value_reg;
    assign frac_count     = frac_count_reg;
    assign int_overflow   = int_overflow_reg;
    assign frac_truncated = frac_truncated_reg;

    `ASSERT_NEVER(a_reject_zero, clk, rst_n, out_valid && !valid_res && |{int_part, frac_value})
    `ASSERT_NEVER(a_reject_flags, clk, rst_n, out_valid && !valid_res && |{frac_count, int_overflow})
    `ASSERT_PROP(a_ovf_sat, clk, rst_n, (out_valid && int_overflow) |-> (&int_part))
    `ASSERT_PROP(a_trunc_full, clk, rst_n, (out_valid && frac_truncated) |-> (frac_count == 5'(MAX_FRAC_DIGITS)))
    `ASSERT_NEVER(a_cnt_limit, clk, rst_n, state_reg.frac_cnt > 5'(MAX_FRAC_DIGITS))

endmodule
`default_nettype wire
